// File: rtl/ptq_pkg.sv
// Shared constants for the periodic task timer queue.
`timescale 1ns / 1ps
package ptq_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned TaskSlotsDefault  = 16;

  // Result status codes
  localparam logic [2:0] ST_ADDED      = 3'd0;
  localparam logic [2:0] ST_DISPATCHED = 3'd1;
  localparam logic [2:0] ST_EMPTY      = 3'd2;
  localparam logic [2:0] ST_QFULL      = 3'd3;
  localparam logic [2:0] ST_TFULL      = 3'd4;

  // Request kinds
  localparam logic KIND_ADD      = 1'b0;
  localparam logic KIND_DISPATCH = 1'b1;

endpackage

// File: rtl/periodic_task_timer_queue_core.sv
// Periodic task timer queue: sorted timer queue with a task table and one shared adder.
`timescale 1ns / 1ps
//
//  channel | signals                                            | role
//  --------+----------------------------------------------------+----------------------------
//  in      | in_valid, in_ready, kind, first_delay, period,     | add or dispatch request
//          | repeat_count, elapsed                              |
//  out     | out_valid, out_ready, task_id, wait_ticks, status  | one result per request
//
//  A full-table, full-queue or empty request goes straight to the result state.
//  An add walks from the tail toward the head, moving each later entry one place up.
//  A dispatch shifts every entry down one place, less the elapsed time, then
//  reinserts the task the same way unless its repeat count is 1. Every walk step is a
//  read then a write on the queue memory (one read port, one write port).
//  Reset: synchronous, clears the state, out_valid and the entry and task counts;
//  the memories need no clearing. Stalls: the block takes a new request while a
//  result waits in the output register and holds its last step until that slot frees.
module periodic_task_timer_queue_core #(
  parameter int unsigned QUEUE_DEPTH = ptq_pkg::QueueDepthDefault,
  parameter int unsigned TASK_SLOTS  = ptq_pkg::TaskSlotsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [30:0] first_delay,
  input  logic [30:0] period,
  input  logic [31:0] repeat_count,
  input  logic [30:0] elapsed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  task_id,
  output logic [30:0] wait_ticks,
  output logic [2:0]  status
);
  import ptq_pkg::*;

  localparam int unsigned QIW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TIDW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned TCW  = $clog2(TASK_SLOTS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_D_HEAD = 3'd1;
  localparam logic [2:0] S_D_RD   = 3'd2;
  localparam logic [2:0] S_D_WR   = 3'd3;
  localparam logic [2:0] S_D_TASK = 3'd4;
  localparam logic [2:0] S_I_CHK  = 3'd5;
  localparam logic [2:0] S_I_CMP  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  typedef struct packed {
    logic signed [31:0] t;
    logic [TIDW-1:0]    k;
  } qent_t;

  typedef struct packed {
    logic [30:0] per;
    logic [31:0] rep;
  } tent_t;

  // memories
  qent_t q_mem [QUEUE_DEPTH];
  tent_t t_mem [TASK_SLOTS];
  qent_t q_rdata;
  tent_t t_rdata;
  logic            q_we;
  logic [QIW-1:0]  q_waddr, q_raddr;
  qent_t           q_wdata;
  logic            t_we;
  logic [TIDW-1:0] t_waddr, t_raddr;
  tent_t           t_wdata;

  // control and working registers
  logic [2:0]         state;
  logic [QCW-1:0]     entry_count;
  logic [TCW-1:0]     task_total;
  logic [QCW-1:0]     idx;
  logic [QCW-1:0]     idx_m1;
  logic [30:0]        elapsed_q;
  logic signed [31:0] ins_t;
  logic [TIDW-1:0]    ins_k;
  logic signed [31:0] head_time;
  logic [TIDW-1:0]    res_id;
  logic [30:0]        res_wait;
  logic [2:0]         res_status;
  logic [7:0]         id8;

  // shared saturating adder
  logic signed [31:0] add_a;
  logic signed [32:0] add_b;
  logic signed [33:0] add_sum;
  logic signed [31:0] add_sat;

  assign idx_m1 = idx - QCW'(1);
  assign in_ready = (state == S_IDLE);

  always_comb begin
    if (state == S_D_TASK) begin
      add_a = head_time;
      add_b = $signed({2'b00, t_rdata.per});
    end else begin
      add_a = q_rdata.t;
      add_b = -$signed({2'b00, elapsed_q});
    end
    add_sum = $signed({{2{add_a[31]}}, add_a}) + $signed({add_b[32], add_b});
    if (add_sum[33:31] == 3'b000 || add_sum[33:31] == 3'b111) begin
      add_sat = add_sum[31:0];
    end else if (add_sum[33]) begin
      add_sat = 32'sh8000_0000;
    end else begin
      add_sat = 32'sh7fff_ffff;
    end
  end

  // memory port control
  always_comb begin
    q_we    = 1'b0;
    q_waddr = idx[QIW-1:0];
    q_wdata = '{t: ins_t, k: ins_k};
    q_raddr = '0;
    t_we    = 1'b0;
    t_waddr = task_total[TIDW-1:0];
    t_wdata = '{per: period, rep: repeat_count};
    t_raddr = q_rdata.k;
    unique case (state)
      S_IDLE: begin
        t_we = in_valid && kind == KIND_ADD && task_total < TCW'(TASK_SLOTS)
               && entry_count < QCW'(QUEUE_DEPTH);
      end
      S_D_RD: q_raddr = idx[QIW-1:0];
      S_D_WR: begin
        q_we    = 1'b1;
        q_waddr = idx_m1[QIW-1:0];
        q_wdata = '{t: add_sat, k: q_rdata.k};
      end
      S_D_TASK: begin
        t_we    = t_rdata.rep != 32'd0 && t_rdata.rep != 32'd1;
        t_waddr = res_id;
        t_wdata = '{per: t_rdata.per, rep: t_rdata.rep - 32'd1};
      end
      S_I_CHK: begin
        q_raddr = idx_m1[QIW-1:0];
        q_we    = (idx == '0);
      end
      S_I_CMP: begin
        q_we = 1'b1;
        if (q_rdata.t > ins_t) q_wdata = q_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_waddr] <= q_wdata;
    q_rdata <= q_mem[q_raddr];
    if (t_we) t_mem[t_waddr] <= t_wdata;
    if (state == S_D_HEAD) t_rdata <= t_mem[t_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      task_total  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            elapsed_q  <= elapsed;
            res_id     <= '0;
            res_wait   <= '0;
            if (kind == KIND_ADD) begin
              if (task_total >= TCW'(TASK_SLOTS)) begin
                res_status <= ST_TFULL;
                state      <= S_DONE;
              end else if (entry_count >= QCW'(QUEUE_DEPTH)) begin
                res_status <= ST_QFULL;
                state      <= S_DONE;
              end else begin
                res_status <= ST_ADDED;
                res_id     <= task_total[TIDW-1:0];
                ins_t      <= $signed({1'b0, first_delay});
                ins_k      <= task_total[TIDW-1:0];
                task_total <= task_total + TCW'(1);
                idx        <= entry_count;
                state      <= S_I_CHK;
              end
            end else if (entry_count == '0) begin
              res_status <= ST_EMPTY;
              state      <= S_DONE;
            end else begin
              // q_raddr defaults to the head
              res_status <= ST_DISPATCHED;
              state      <= S_D_HEAD;
            end
          end
        end
        S_D_HEAD: begin
          res_id    <= q_rdata.k;
          res_wait  <= q_rdata.t[31] ? 31'd0 : q_rdata.t[30:0];
          head_time <= add_sat;
          idx       <= QCW'(1);
          state     <= S_D_RD;
        end
        S_D_RD: begin
          if (idx < entry_count) begin
            state <= S_D_WR;
          end else begin
            entry_count <= entry_count - QCW'(1);
            state       <= S_D_TASK;
          end
        end
        S_D_WR: begin
          idx   <= idx + QCW'(1);
          state <= S_D_RD;
        end
        S_D_TASK: begin
          if (t_rdata.rep == 32'd1) begin
            state <= S_DONE;
          end else begin
            ins_t <= add_sat;
            ins_k <= res_id;
            idx   <= entry_count;
            state <= S_I_CHK;
          end
        end
        S_I_CHK: begin
          if (idx == '0) begin
            entry_count <= entry_count + QCW'(1);
            state       <= S_DONE;
          end else begin
            state <= S_I_CMP;
          end
        end
        S_I_CMP: begin
          if (q_rdata.t > ins_t) begin
            idx   <= idx_m1;
            state <= S_I_CHK;
          end else begin
            entry_count <= entry_count + QCW'(1);
            state       <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register, loaded as the request completes
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      task_id    <= id8[3:0];
      wait_ticks <= res_wait;
      status     <= res_status;
    end
  end

  assign id8 = 8'(res_id);

endmodule

// File: tb/tb_periodic_task_timer_queue_core.sv
// Testbench for the periodic task timer queue: random add/dispatch traffic checked against a model.
`timescale 1ns / 1ps
import ptq_pkg::*;

// Scoreboard: mirrors the queue and task table, keeps expected results in order.
class ptq_scoreboard;
  int signed   slot_time[16];
  logic [3:0]  slot_task[16];
  int unsigned slot_count;
  logic [30:0] tbl_period[16];
  logic [31:0] tbl_left[16];
  int unsigned tbl_total;
  logic [3:0]  want_id[$];
  logic [30:0] want_wait[$];
  logic [2:0]  want_status[$];
  int unsigned errors;

  function new();
    slot_count = 0;
    tbl_total  = 0;
    errors     = 0;
  endfunction

  function int signed sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  // Insert after every entry with time <= t.
  function void place(int signed t, logic [3:0] id);
    int unsigned pos;
    pos = 0;
    while (pos < slot_count && slot_time[pos] <= t) pos++;
    for (int unsigned i = slot_count; i > pos; i--) begin
      slot_time[i] = slot_time[i-1];
      slot_task[i] = slot_task[i-1];
    end
    slot_time[pos] = t;
    slot_task[pos] = id;
    slot_count++;
  endfunction

  function void note_request(logic k, logic [30:0] fd, logic [30:0] per,
                             logic [31:0] rc, logic [30:0] el);
    logic [3:0]  id;
    logic [30:0] w;
    logic [2:0]  st;
    int signed   head;
    id = '0;
    w  = '0;
    if (k == KIND_ADD) begin
      if (tbl_total >= 16) st = ST_TFULL;
      else if (slot_count >= 16) st = ST_QFULL;
      else begin
        id = tbl_total[3:0];
        tbl_period[id] = per;
        tbl_left[id] = rc;
        place(int'({1'b0, fd}), id);
        tbl_total++;
        st = ST_ADDED;
      end
    end else if (slot_count == 0) begin
      st = ST_EMPTY;
    end else begin
      id = slot_task[0];
      w  = (slot_time[0] < 0) ? 31'd0 : slot_time[0][30:0];
      for (int unsigned i = 0; i < slot_count; i++)
        slot_time[i] = sat32(longint'(slot_time[i]) - longint'({1'b0, el}));
      head = slot_time[0];
      for (int unsigned i = 1; i < slot_count; i++) begin
        slot_time[i-1] = slot_time[i];
        slot_task[i-1] = slot_task[i];
      end
      slot_count--;
      if (tbl_left[id] != 1) begin
        if (tbl_left[id] != 0) tbl_left[id] = tbl_left[id] - 32'd1;
        place(sat32(longint'(head) + longint'({1'b0, tbl_period[id]})), id);
      end
      st = ST_DISPATCHED;
    end
    want_id.push_back(id);
    want_wait.push_back(w);
    want_status.push_back(st);
  endfunction

  function void check_result(logic [3:0] id, logic [30:0] w, logic [2:0] st);
    logic [3:0]  e_id;
    logic [30:0] e_w;
    logic [2:0]  e_st;
    if (want_id.size() == 0) begin
      $display("%0t: unexpected result id=%0d wait=%0d status=%0d", $time, id, w, st);
      errors++;
      return;
    end
    e_id = want_id.pop_front();
    e_w  = want_wait.pop_front();
    e_st = want_status.pop_front();
    if (id !== e_id) begin
      $display("%0t: task_id expected %0d actual %0d", $time, e_id, id);
      errors++;
    end
    if (w !== e_w) begin
      $display("%0t: wait_ticks expected %0d actual %0d", $time, e_w, w);
      errors++;
    end
    if (st !== e_st) begin
      $display("%0t: status expected %0d actual %0d", $time, e_st, st);
      errors++;
    end
  endfunction
endclass

module tb_periodic_task_timer_queue_core;
  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        kind;
  logic [30:0] first_delay;
  logic [30:0] period;
  logic [31:0] repeat_count;
  logic [30:0] elapsed;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  task_id;
  logic [30:0] wait_ticks;
  logic [2:0]  status;

  ptq_scoreboard board;
  longint unsigned cycles;
  bit          sink_hold;   // long receiver hold-off requested
  bit          stim_done;

  periodic_task_timer_queue_core u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .first_delay(first_delay), .period(period),
    .repeat_count(repeat_count), .elapsed(elapsed),
    .out_valid(out_valid), .out_ready(out_ready),
    .task_id(task_id), .wait_ticks(wait_ticks), .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: sized for roughly 800 requests at the slowest request plus sender gap and stall.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Offer one request and hold it until accepted.
  task automatic send_request(logic k, logic [30:0] fd, logic [30:0] per,
                              logic [31:0] rc, logic [30:0] el);
    in_valid     <= 1'b1;
    kind         <= k;
    first_delay  <= fd;
    period       <= per;
    repeat_count <= rc;
    elapsed      <= el;
    do @(posedge clk); while (!in_ready);
    board.note_request(k, fd, per, rc, el);
  endtask

  task automatic send_with_gap(logic k, logic [30:0] fd, logic [30:0] per,
                               logic [31:0] rc, logic [30:0] el, bit gaps);
    int unsigned gap;
    gap = gaps ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    send_request(k, fd, per, rc, el);
  endtask

  // Wait until every expected result has arrived.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.want_id.size() != 0) @(posedge clk);
  endtask

  // Small times mostly, extremes now and then.
  function automatic logic [30:0] pick_ticks();
    case ($urandom_range(0, 9))
      0: return 31'h7fffffff;
      1: return 31'd0;
      2: return 31'($urandom());
      default: return 31'($urandom_range(0, 200));
    endcase
  endfunction

  function automatic logic [31:0] pick_repeats();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hffffffff;
      2: return $urandom();
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  // Receiver: random stalls, plus one long hold-off when asked.
  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (sink_hold) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        sink_hold = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (stim_done) stall = 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_result(task_id, wait_ticks, status);
    end
  end

  initial begin
    int unsigned phase_len;
    bit gaps;
    board = new();
    sink_hold = 1'b0;
    stim_done = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    kind <= KIND_ADD;
    first_delay <= '0;
    period <= '0;
    repeat_count <= '0;
    elapsed <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty dispatch, extreme adds, saturation both ways, clamp.
    send_request(KIND_DISPATCH, 31'd0, 31'd0, 32'd0, 31'h7fffffff);
    send_request(KIND_ADD, 31'h7fffffff, 31'h7fffffff, 32'd0, 31'd0);
    send_request(KIND_ADD, 31'd0, 31'd0, 32'd1, 31'd0);
    send_request(KIND_ADD, 31'd5, 31'd3, 32'd2, 31'd0);
    send_request(KIND_ADD, 31'd5, 31'd7, 32'hffffffff, 31'd0);  // equal time goes after
    send_request(KIND_DISPATCH, 31'd0, 31'd0, 32'd0, 31'd0);
    repeat (4) send_request(KIND_DISPATCH, 31'h7fffffff, 31'h7fffffff, 32'hffffffff,
                            31'h7fffffff);                    // drive negative, clamp
    repeat (4) send_request(KIND_DISPATCH, 31'd0, 31'd0, 32'd0, 31'h7fffffff);
    // Long receiver hold-off while the sender keeps offering.
    sink_hold = 1'b1;
    repeat (6) send_request(KIND_ADD, 31'($urandom()), 31'($urandom()), 32'd3,
                            31'($urandom()));
    drain();

    // Random phases. The task table only holds 16 tasks per reset, so every phase
    // dispatches heavily; the table fills early and the full-table case recurs.
    for (int p = 0; p < 8; p++) begin
      phase_len = 90;
      gaps = (p % 3) != 2;
      for (int unsigned n = 0; n < phase_len; n++) begin
        if ($urandom_range(0, 3) == 0)
          send_with_gap(KIND_ADD, pick_ticks(), pick_ticks(), pick_repeats(),
                        31'($urandom()), gaps);
        else
          send_with_gap(KIND_DISPATCH, 31'($urandom()), 31'($urandom()), $urandom(),
                        pick_ticks(), gaps);
      end
      // Sender pauses until every result is back.
      drain();
    end
    stim_done = 1'b1;
    drain();
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.want_id.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
